FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the plane-constant pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define PFTP_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("pftp assertion failed");

// An implication checked at every clock edge outside reset.
`define PFTP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pftp implication failed");

`endif

FILE: rtl/pftp_pkg.sv
// ----------------------------------------------------------------------------
// pftp_pkg
// Widths, limits, register codes and the saturation helper of the plane unit.
// ----------------------------------------------------------------------------
package pftp_pkg;

	localparam int COORD_BITS_DEF     = 16;
	localparam int COEF_FRAC_BITS_DEF = 24;
	localparam int REG_W              = 41;
	localparam int COEF_W             = 63;
	localparam int WIDE_W             = 128;
	localparam int NUM_W              = COEF_W + REG_W;
	localparam int DIV_STAGES         = COEF_W + 1;
	localparam int CFG_IDX_W          = 8;

	localparam logic [REG_W-1:0] ZERO_THR_RST = 41'd1678;
	localparam logic [REG_W-1:0] MIN_MAG_RST  = 41'd16777216;

	localparam logic [COEF_W-1:0] POS_LIM = 63'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [COEF_W-1:0] NEG_LIM = 63'h4000_0000_0000_0000;
	localparam logic signed [WIDE_W-1:0] POS_LIM_W = 128'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [WIDE_W-1:0] NEG_LIM_W = -128'sh4000_0000_0000_0000;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_THR = 8'd0,
		REG_MIN_MAG  = 8'd1
	} cfg_reg_t;

	// One plane constant in sign and magnitude form.
	typedef struct packed {
		logic              neg;
		logic [COEF_W-1:0] mag;
		logic              sat;
	} coef_t;

	// Clip a wide signed value to the 63-bit output range.
	function automatic coef_t sat_coef(input logic signed [WIDE_W-1:0] v);
		coef_t r;
		logic signed [WIDE_W-1:0] nv;
		nv    = -v;
		r.neg = v[WIDE_W-1];
		r.sat = 1'b0;
		if (v > POS_LIM_W) begin
			r.mag = POS_LIM;
			r.sat = 1'b1;
		end else if (v < NEG_LIM_W) begin
			r.mag = NEG_LIM;
			r.sat = 1'b1;
		end else if (r.neg) begin
			r.mag = nv[COEF_W-1:0];
		end else begin
			r.mag = v[COEF_W-1:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/pftp_div.sv
// ----------------------------------------------------------------------------
// pftp_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module pftp_div (
	input  logic                          clk,
	input  logic [pftp_pkg::NUM_W-1:0]    num,
	input  logic [pftp_pkg::REG_W-1:0]    den,
	output logic [pftp_pkg::COEF_W-1:0]   quo,
	output logic                          ovf
);

	localparam int RW = pftp_pkg::REG_W;
	localparam int QW = pftp_pkg::COEF_W;
	localparam int NS = pftp_pkg::DIV_STAGES;

	logic [RW-1:0] rem_s [NS];
	logic [QW-1:0] low_s [NS];
	logic [QW-1:0] quo_s [NS];
	logic [RW-1:0] den_s [NS];
	logic          ovf_s [NS];

	// First stage: the quotient overflows when the upper numerator part reaches den.
	always_ff @(posedge clk) begin
		rem_s[0] <= num[pftp_pkg::NUM_W-1:QW];
		low_s[0] <= num[QW-1:0];
		quo_s[0] <= '0;
		den_s[0] <= den;
		ovf_s[0] <= (num[pftp_pkg::NUM_W-1:QW] >= den);
	end

	// Each later stage decides one quotient bit, most significant first.
	for (genvar k = 1; k < NS; k++) begin : g_stage
		localparam int BI = QW - k;
		logic [RW:0]   trial;
		logic [RW:0]   diff;
		logic          take;
		always_comb begin
			trial = {rem_s[k-1], low_s[k-1][BI]};
			diff  = trial - {1'b0, den_s[k-1]};
			take  = (trial >= {1'b0, den_s[k-1]});
		end
		always_ff @(posedge clk) begin
			rem_s[k] <= take ? diff[RW-1:0] : trial[RW-1:0];
			low_s[k] <= low_s[k-1];
			quo_s[k] <= quo_s[k-1] | (QW'(take) << BI);
			den_s[k] <= den_s[k-1];
			ovf_s[k] <= ovf_s[k-1];
		end
	end

	assign quo = quo_s[NS-1];
	assign ovf = ovf_s[NS-1];

endmodule

FILE: rtl/plane_from_three_points_top.sv
// ----------------------------------------------------------------------------
// plane_from_three_points_top
// Plane constants A, B, C, D from three points, with threshold and rescale.
// ----------------------------------------------------------------------------
// Usage: drive the nine coordinates and raise start; a point triple is taken
// at every edge where start is high and busy is low. busy is always low, so a
// new triple may enter in every cycle and the sustained rate is one item per
// clock.
// A result sits on coef_a..coef_d and the three flags for one cycle marked by
// done. The receiver cannot hold results off; every item gives one result, in
// order.
// The pipeline holds nine arithmetic stages (products, sums, alignment,
// thresholding, minimum search, rescale multiply), the 64-stage divider that
// forms |c| * min_magnitude / smallest one quotient bit in each stage after
// its first, and one output register.
// Configuration uses its own channel: cfg_ready is always high, and a transfer
// writes cfg_data into the register named by cfg_index (0 zero_threshold,
// 1 min_magnitude); other indexes are ignored. Write only while idle.
// Reset clears the pipeline valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plane_from_three_points_top #(
	parameter int COORD_BITS     = pftp_pkg::COORD_BITS_DEF,
	parameter int COEF_FRAC_BITS = pftp_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [COORD_BITS-1:0]         p1_x,
	input  logic signed [COORD_BITS-1:0]         p1_y,
	input  logic signed [COORD_BITS-1:0]         p1_z,
	input  logic signed [COORD_BITS-1:0]         p2_x,
	input  logic signed [COORD_BITS-1:0]         p2_y,
	input  logic signed [COORD_BITS-1:0]         p2_z,
	input  logic signed [COORD_BITS-1:0]         p3_x,
	input  logic signed [COORD_BITS-1:0]         p3_y,
	input  logic signed [COORD_BITS-1:0]         p3_z,
	output logic                                 done,
	output logic signed [pftp_pkg::COEF_W-1:0]   coef_a,
	output logic signed [pftp_pkg::COEF_W-1:0]   coef_b,
	output logic signed [pftp_pkg::COEF_W-1:0]   coef_c,
	output logic signed [pftp_pkg::COEF_W-1:0]   coef_d,
	output logic                                 degenerate,
	output logic                                 rescaled,
	output logic                                 saturated,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pftp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pftp_pkg::REG_W-1:0]           cfg_data
);

	localparam int CB   = COORD_BITS;
	localparam int CF   = COORD_BITS / 2;
	localparam int CW   = pftp_pkg::COEF_W;
	localparam int RW   = pftp_pkg::REG_W;
	localparam int WW   = pftp_pkg::WIDE_W;
	localparam int NW   = pftp_pkg::NUM_W;
	localparam int NS   = pftp_pkg::DIV_STAGES;
	localparam int PRE  = 9;
	localparam int LAT  = PRE + NS + 1;
	localparam int SH2  = COEF_FRAC_BITS - 2 * CF;
	localparam int SH3  = COEF_FRAC_BITS - 3 * CF;
	localparam int SH2L = (SH2 > 0) ? SH2 : 0;
	localparam int SH2R = (SH2 < 0) ? -SH2 : 0;
	localparam int SH3L = (SH3 > 0) ? SH3 : 0;
	localparam int SH3R = (SH3 < 0) ? -SH3 : 0;

	// Configuration registers and valid line.
	logic [RW-1:0] zero_thr_q;
	logic [RW-1:0] min_mag_q;
	logic          vld_q [LAT];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_thr_q <= pftp_pkg::ZERO_THR_RST;
			min_mag_q  <= pftp_pkg::MIN_MAG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pftp_pkg::REG_ZERO_THR: zero_thr_q <= cfg_data;
				pftp_pkg::REG_MIN_MAG:  min_mag_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits travel alongside the data; nothing ever stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
		end else begin
			vld_q[0] <= start && !busy;
			for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// Stage 1: coordinate differences and the cross products inside D.
	logic signed [CB-1:0]   x_s1 [3];
	logic signed [CB-1:0]   y_s1 [3];
	logic signed [CB-1:0]   z_s1 [3];
	logic signed [CB:0]     dx_s1 [3];
	logic signed [CB:0]     dy_s1 [3];
	logic signed [CB:0]     dz_s1 [3];
	logic signed [2*CB-1:0] pd_s1 [6];

	always_ff @(posedge clk) begin
		x_s1[0] <= p1_x; x_s1[1] <= p2_x; x_s1[2] <= p3_x;
		y_s1[0] <= p1_y; y_s1[1] <= p2_y; y_s1[2] <= p3_y;
		z_s1[0] <= p1_z; z_s1[1] <= p2_z; z_s1[2] <= p3_z;
		dx_s1[0] <= (CB+1)'(p2_x) - (CB+1)'(p3_x);
		dx_s1[1] <= (CB+1)'(p3_x) - (CB+1)'(p1_x);
		dx_s1[2] <= (CB+1)'(p1_x) - (CB+1)'(p2_x);
		dy_s1[0] <= (CB+1)'(p2_y) - (CB+1)'(p3_y);
		dy_s1[1] <= (CB+1)'(p3_y) - (CB+1)'(p1_y);
		dy_s1[2] <= (CB+1)'(p1_y) - (CB+1)'(p2_y);
		dz_s1[0] <= (CB+1)'(p2_z) - (CB+1)'(p3_z);
		dz_s1[1] <= (CB+1)'(p3_z) - (CB+1)'(p1_z);
		dz_s1[2] <= (CB+1)'(p1_z) - (CB+1)'(p2_z);
		pd_s1[0] <= p2_y * p3_z;
		pd_s1[1] <= p3_y * p2_z;
		pd_s1[2] <= p3_y * p1_z;
		pd_s1[3] <= p1_y * p3_z;
		pd_s1[4] <= p1_y * p2_z;
		pd_s1[5] <= p2_y * p1_z;
	end

	// Stage 2: products for A, B, C and the inner differences of D.
	logic signed [2*CB:0]   pa_s2 [3];
	logic signed [2*CB:0]   pb_s2 [3];
	logic signed [2*CB:0]   pc_s2 [3];
	logic signed [2*CB:0]   id_s2 [3];
	logic signed [CB-1:0]   x_s2 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pa_s2[i] <= y_s1[i] * dz_s1[i];
			pb_s2[i] <= z_s1[i] * dx_s1[i];
			pc_s2[i] <= x_s1[i] * dy_s1[i];
			id_s2[i] <= (2*CB+1)'(pd_s1[2*i]) - (2*CB+1)'(pd_s1[2*i+1]);
			x_s2[i]  <= x_s1[i];
		end
	end

	// Stage 3: sums for A, B, C and the outer products of D.
	logic signed [2*CB+2:0] a_s3, b_s3, c_s3;
	logic signed [3*CB:0]   pdx_s3 [3];

	always_ff @(posedge clk) begin
		a_s3 <= (2*CB+3)'(pa_s2[0]) + (2*CB+3)'(pa_s2[1]) + (2*CB+3)'(pa_s2[2]);
		b_s3 <= (2*CB+3)'(pb_s2[0]) + (2*CB+3)'(pb_s2[1]) + (2*CB+3)'(pb_s2[2]);
		c_s3 <= (2*CB+3)'(pc_s2[0]) + (2*CB+3)'(pc_s2[1]) + (2*CB+3)'(pc_s2[2]);
		for (int i = 0; i < 3; i++) pdx_s3[i] <= x_s2[i] * id_s2[i];
	end

	// Stage 4: D as the negated triple product.
	logic signed [2*CB+2:0] a_s4, b_s4, c_s4;
	logic signed [3*CB+3:0] d_s4;

	always_ff @(posedge clk) begin
		a_s4 <= a_s3;
		b_s4 <= b_s3;
		c_s4 <= c_s3;
		d_s4 <= -((3*CB+4)'(pdx_s3[0]) + (3*CB+4)'(pdx_s3[1]) + (3*CB+4)'(pdx_s3[2]));
	end

	// Stage 5: align to the output fraction and clip to 63 bits.
	logic signed [WW-1:0] al_w [4];
	pftp_pkg::coef_t      k_s5 [4];

	always_comb begin
		al_w[0] = (WW'(a_s4) <<< SH2L) >>> SH2R;
		al_w[1] = (WW'(b_s4) <<< SH2L) >>> SH2R;
		al_w[2] = (WW'(c_s4) <<< SH2L) >>> SH2R;
		al_w[3] = (WW'(d_s4) <<< SH3L) >>> SH3R;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) k_s5[i] <= pftp_pkg::sat_coef(al_w[i]);
	end

	// Stage 6: zero small constants and take pairwise minimums of survivors.
	logic          sv_c [4];
	logic [CW-1:0] km_s6 [4];
	logic          neg_s6 [4];
	logic          sat_s6;
	logic [CW-1:0] m01_s6, m23_s6;
	logic          any01_s6, any23_s6;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sv_c[i] = (k_s5[i].mag >= CW'(zero_thr_q)) && (k_s5[i].mag != '0);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			km_s6[i]  <= sv_c[i] ? k_s5[i].mag : '0;
			neg_s6[i] <= k_s5[i].neg;
		end
		sat_s6   <= k_s5[0].sat || k_s5[1].sat || k_s5[2].sat || k_s5[3].sat;
		any01_s6 <= sv_c[0] || sv_c[1];
		any23_s6 <= sv_c[2] || sv_c[3];
		if (sv_c[0] && (!sv_c[1] || k_s5[0].mag < k_s5[1].mag)) m01_s6 <= k_s5[0].mag;
		else m01_s6 <= k_s5[1].mag;
		if (sv_c[2] && (!sv_c[3] || k_s5[2].mag < k_s5[3].mag)) m23_s6 <= k_s5[2].mag;
		else m23_s6 <= k_s5[3].mag;
	end

	// Stage 7: smallest survivor and the rescale decision.
	logic [CW-1:0] small_c;
	logic          any_c;
	logic [CW-1:0] km_s7 [4];
	logic          neg_s7 [4];
	logic          sat_s7, any_s7, resc_s7;
	logic [RW-1:0] den_s7;

	always_comb begin
		any_c = any01_s6 || any23_s6;
		if (any01_s6 && (!any23_s6 || m01_s6 < m23_s6)) small_c = m01_s6;
		else small_c = m23_s6;
	end

	always_ff @(posedge clk) begin
		km_s7   <= km_s6;
		neg_s7  <= neg_s6;
		sat_s7  <= sat_s6;
		any_s7  <= any_c;
		resc_s7 <= any_c && (small_c < CW'(min_mag_q));
		den_s7  <= (any_c && (small_c < CW'(min_mag_q))) ? small_c[RW-1:0] : RW'(1);
	end

	// Stage 8: partial products of |c| * min_magnitude.
	logic [63:0]   pll_s8 [4];
	logic [40:0]   plh_s8 [4];
	logic [62:0]   phl_s8 [4];
	logic [39:0]   phh_s8 [4];
	logic [CW-1:0] km_s8 [4];
	logic          neg_s8 [4];
	logic          sat_s8, any_s8, resc_s8;
	logic [RW-1:0] den_s8;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			pll_s8[i] <= 64'(km_s7[i][31:0]) * 64'(min_mag_q[31:0]);
			plh_s8[i] <= 41'(km_s7[i][31:0]) * 41'(min_mag_q[RW-1:32]);
			phl_s8[i] <= 63'(km_s7[i][CW-1:32]) * 63'(min_mag_q[31:0]);
			phh_s8[i] <= 40'(km_s7[i][CW-1:32]) * 40'(min_mag_q[RW-1:32]);
		end
		km_s8   <= km_s7;
		neg_s8  <= neg_s7;
		sat_s8  <= sat_s7;
		any_s8  <= any_s7;
		resc_s8 <= resc_s7;
		den_s8  <= den_s7;
	end

	// Stage 9: full numerator.
	logic [NW-1:0] num_s9 [4];
	logic [CW-1:0] km_s9 [4];
	logic          neg_s9 [4];
	logic          sat_s9, any_s9, resc_s9;
	logic [RW-1:0] den_s9;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			num_s9[i] <= NW'(pll_s8[i]) + (NW'(plh_s8[i]) << 32)
				+ (NW'(phl_s8[i]) << 32) + (NW'(phh_s8[i]) << 64);
		end
		km_s9   <= km_s8;
		neg_s9  <= neg_s8;
		sat_s9  <= sat_s8;
		any_s9  <= any_s8;
		resc_s9 <= resc_s8;
		den_s9  <= den_s8;
	end

	// Divider lanes, one per constant.
	logic [CW-1:0] quo_w [4];
	logic          ovf_w [4];

	for (genvar g = 0; g < 4; g++) begin : g_div
		pftp_div u_div (
			.clk (clk),
			.num (num_s9[g]),
			.den (den_s9),
			.quo (quo_w[g]),
			.ovf (ovf_w[g])
		);
	end

	// Side data waits alongside the divider.
	logic [CW-1:0] km_dl  [NS][4];
	logic          neg_dl [NS][4];
	logic          sat_dl [NS];
	logic          any_dl [NS];
	logic          resc_dl [NS];

	always_ff @(posedge clk) begin
		km_dl[0]   <= km_s9;
		neg_dl[0]  <= neg_s9;
		sat_dl[0]  <= sat_s9;
		any_dl[0]  <= any_s9;
		resc_dl[0] <= resc_s9;
		for (int i = 1; i < NS; i++) begin
			km_dl[i]   <= km_dl[i-1];
			neg_dl[i]  <= neg_dl[i-1];
			sat_dl[i]  <= sat_dl[i-1];
			any_dl[i]  <= any_dl[i-1];
			resc_dl[i] <= resc_dl[i-1];
		end
	end

	// Output stage: pick rescaled or plain magnitudes and restore signs.
	logic [CW-1:0] mag_c [4];
	logic [CW-1:0] lim_c [4];
	logic          clip_c [4];
	logic [CW-1:0] res_c [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lim_c[i]  = neg_dl[NS-1][i] ? pftp_pkg::NEG_LIM : pftp_pkg::POS_LIM;
			clip_c[i] = resc_dl[NS-1] && (ovf_w[i] || quo_w[i] > lim_c[i]);
			if (!resc_dl[NS-1]) mag_c[i] = km_dl[NS-1][i];
			else if (clip_c[i]) mag_c[i] = lim_c[i];
			else mag_c[i] = quo_w[i];
			res_c[i] = neg_dl[NS-1][i] ? -mag_c[i] : mag_c[i];
		end
	end

	always_ff @(posedge clk) begin
		coef_a     <= res_c[0];
		coef_b     <= res_c[1];
		coef_c     <= res_c[2];
		coef_d     <= res_c[3];
		degenerate <= !any_dl[NS-1];
		rescaled   <= resc_dl[NS-1];
		saturated  <= sat_dl[NS-1] || clip_c[0] || clip_c[1] || clip_c[2] || clip_c[3];
	end

	// All four output constants read zero.
	logic coef_zero_c;
	assign coef_zero_c = (coef_a == '0) && (coef_b == '0) && (coef_c == '0)
		&& (coef_d == '0);

	// Checks on result timing and flag consistency.
	`PFTP_ASSERT_IMPLY(a_done_lat, clk, arst_n, done, $past(start && !busy, LAT))
	`PFTP_ASSERT_IMPLY(a_degen_zero, clk, arst_n, done && degenerate, coef_zero_c)
	`PFTP_ASSERT_ALWAYS(a_degen_resc, clk, arst_n, !done || !(degenerate && rescaled))

endmodule
